@@ rtl/core/alrs_pkg.sv @@
// Shared constants and control structs for the auto levels RGB stretch block.
`default_nettype none

package alrs_pkg;

    localparam int COUNT_WIDTH_DEF = 24;
    localparam int PIX_W           = 8;
    localparam int CHANNELS        = 3;
    localparam int CUT_W           = 14;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CUT_W-1:0]     FRACTION_ONE = 14'd10000;
    localparam logic [CUT_W-1:0]     CUT_RESET    = 14'd40;
    localparam logic [PIX_W-1:0]     FULL_SCALE   = 8'd255;
    localparam logic [PIX_W-1:0]     LEVEL_LAST   = 8'd255;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_CUT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_CUT = 2'd1;

    // Sequencer end counts: a scan issues 256 reads and drains a three-stage pipe.
    localparam logic [8:0] SCAN_LAST = 9'd258;
    localparam logic [8:0] DIV_LAST  = 9'd9;

    typedef struct packed {
        logic             restart;
        logic             high;
        logic             issue;
        logic [PIX_W-1:0] idx;
    } scan_ctl_t;

    typedef struct packed {
        logic             div_start;
        logic             we;
        logic [PIX_W-1:0] idx;
    } build_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/auto_levels_rgb_stretch.sv @@
// Top level of the per-channel auto levels (percentile contrast stretch) block.
//
// Pixels arrive on the s_ stream: tdata holds blue, green and red, tuser picks
// the pass (0 counts the pixel into the histograms, 1 maps it through the
// stretch tables) and tlast marks the final pixel of a pass. Mapped pixels
// leave on the m_ stream, one per apply request, with tlast copied across.
// Histogram requests produce no output.
// For each request the histogram, table or lookup memory is read in the
// accept cycle and written back or registered in the next one, so the
// block takes no new request until that is done. A mapped pixel passes
// the lookup read register and the output register on its way to m_tvalid.
// After the last histogram request the block finds the cuts with a low scan
// and a high scan, divides and writes the tables, while s_tready stays low.
// Reset, and the last apply request, start a pass that clears the histograms
// and the pixel count; no pixel is accepted meanwhile.
// The output register holds a result while m_tready is low; an apply request
// is taken only when that register is free or being emptied in the same cycle.
// Cut registers are written on the cfg_ channel, which is always ready.
`default_nettype none

module auto_levels_rgb_stretch #(
    parameter int COUNT_WIDTH = alrs_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [alrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [alrs_pkg::CUT_W-1:0]     cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [23:0]                    s_tdata,   // blue_in, green_in, red_in
    input  wire logic                           s_tuser,   // operation
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [23:0]                    m_tdata,   // blue_out, green_out, red_out
    output logic                                m_tlast
);

    localparam int W      = alrs_pkg::PIX_W;
    localparam int CH     = alrs_pkg::CHANNELS;
    localparam int NEED_W = COUNT_WIDTH + alrs_pkg::CUT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HIST  = 8'b0000_0100,
        S_APPLY = 8'b0000_1000,
        S_LOW   = 8'b0001_0000,
        S_HIGH  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_BUILD = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [8:0]              cnt_reg, cnt_next;
    logic [alrs_pkg::CUT_W-1:0] low_cfg_reg, high_cfg_reg;
    logic [COUNT_WIDTH-1:0]  count_reg;
    logic [NEED_W-1:0]       need_reg;
    logic [CH-1:0][W-1:0]    addr_reg;
    logic                    last_reg;
    logic                    out_valid_reg;
    logic [CH-1:0][W-1:0]    out_data_reg;
    logic                    out_last_reg;

    logic                    accept;
    logic                    scanning;
    alrs_pkg::scan_ctl_t     scan_ctl;
    alrs_pkg::build_ctl_t    build_ctl;
    logic [CH-1:0][W-1:0]    pix_in;
    logic [CH-1:0][W-1:0]    lut_data;
    logic [CH-1:0][COUNT_WIDTH-1:0] hist_data;
    logic [CH-1:0][W-1:0]    low_cut, high_cut;
    logic                    hist_rd_en;
    logic [CH-1:0][W-1:0]    hist_rd_addr;
    logic                    hist_wr_en;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign pix_in    = s_tdata;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    // Both cut scans sweep all bins; the high scan walks down from the top.
    assign scanning          = (state_reg == S_LOW) || (state_reg == S_HIGH);
    assign scan_ctl.restart  = scanning && (cnt_reg == 9'd0);
    assign scan_ctl.high     = (state_reg == S_HIGH);
    assign scan_ctl.issue    = scanning && !cnt_reg[8];
    assign scan_ctl.idx      = (state_reg == S_HIGH) ? (alrs_pkg::LEVEL_LAST - cnt_reg[W-1:0])
                                                     : cnt_reg[W-1:0];

    assign build_ctl.div_start = (state_reg == S_DIV) && (cnt_reg == 9'd0);
    assign build_ctl.we        = (state_reg == S_BUILD);
    assign build_ctl.idx       = cnt_reg[W-1:0];

    assign hist_rd_en = (accept && !s_tuser) || scan_ctl.issue;
    assign hist_wr_en = (state_reg == S_HIST) || (state_reg == S_CLEAR);

    for (genvar c = 0; c < CH; c++)
    begin : g_ch
        logic [COUNT_WIDTH-1:0] wr_data;

        assign hist_rd_addr[c] = scanning ? scan_ctl.idx : pix_in[c];
        // A full bin stays at its maximum; the clear pass writes zero.
        assign wr_data = (state_reg == S_CLEAR)     ? '0 :
                         (hist_data[c] == COUNT_MAX) ? hist_data[c] :
                                                       hist_data[c] + COUNT_WIDTH'(1);

        alrs_hist_mem #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_hist (
            .clk     (clk),
            .rd_en   (hist_rd_en),
            .rd_addr (hist_rd_addr[c]),
            .rd_data (hist_data[c]),
            .wr_en   (hist_wr_en),
            .wr_addr ((state_reg == S_CLEAR) ? cnt_reg[W-1:0] : addr_reg[c]),
            .wr_data (wr_data)
        );

        alrs_scan #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_scan (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (scan_ctl),
            .hist_data (hist_data[c]),
            .need      (need_reg),
            .low_cut   (low_cut[c]),
            .high_cut  (high_cut[c])
        );

        alrs_lut u_lut (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (build_ctl),
            .low_cut  (low_cut[c]),
            .high_cut (high_cut[c]),
            .rd_en    (accept && s_tuser),
            .rd_addr  (pix_in[c]),
            .rd_data  (lut_data[c])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg[W-1:0] == alrs_pkg::LEVEL_LAST)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = s_tuser ? S_APPLY : S_HIST;
                end
            end
            S_HIST:
            begin
                cnt_next   = '0;
                state_next = last_reg ? S_LOW : S_IDLE;
            end
            S_APPLY:
            begin
                cnt_next   = '0;
                state_next = last_reg ? S_CLEAR : S_IDLE;
            end
            S_LOW, S_HIGH:
            begin
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == alrs_pkg::SCAN_LAST)
                begin
                    state_next = (state_reg == S_LOW) ? S_HIGH : S_DIV;
                    cnt_next   = '0;
                end
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == alrs_pkg::DIV_LAST)
                begin
                    state_next = S_BUILD;
                    cnt_next   = '0;
                end
            end
            S_BUILD:
            begin
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg[W-1:0] == alrs_pkg::LEVEL_LAST)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            low_cfg_reg   <= alrs_pkg::CUT_RESET;
            high_cfg_reg  <= alrs_pkg::CUT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    alrs_pkg::REG_LOW_CUT:  low_cfg_reg  <= cfg_data;
                    alrs_pkg::REG_HIGH_CUT: high_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == S_CLEAR)
            begin
                count_reg <= '0;
            end
            else if ((state_reg == S_HIST) && (count_reg != COUNT_MAX))
            begin
                count_reg <= count_reg + COUNT_WIDTH'(1);
            end

            if (state_reg == S_APPLY)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg <= pix_in;
            last_reg <= s_tlast;
        end
        // The threshold for the scan is formed while its first read is in flight.
        if (scan_ctl.restart)
        begin
            need_reg <= NEED_W'(scan_ctl.high ? high_cfg_reg : low_cfg_reg)
                        * NEED_W'(count_reg);
        end
        if (state_reg == S_APPLY)
        begin
            out_data_reg <= lut_data;
            out_last_reg <= last_reg;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/alrs_hist_mem.sv @@
// One channel's histogram memory with a registered read port and a write port.
`default_nettype none

module alrs_hist_mem #(
    parameter int COUNT_WIDTH = alrs_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [alrs_pkg::PIX_W-1:0] rd_addr,
    output logic      [COUNT_WIDTH-1:0]     rd_data,
    input  wire logic                       wr_en,
    input  wire logic [alrs_pkg::PIX_W-1:0] wr_addr,
    input  wire logic [COUNT_WIDTH-1:0]     wr_data
);

    logic [COUNT_WIDTH-1:0] mem [2**alrs_pkg::PIX_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/alrs_scan.sv @@
// Cumulative histogram scan that finds the low and high cut bins of one channel.
`default_nettype none

module alrs_scan #(
    parameter int COUNT_WIDTH = alrs_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire alrs_pkg::scan_ctl_t                  ctl,
    input  wire logic [COUNT_WIDTH-1:0]               hist_data,
    input  wire logic [COUNT_WIDTH+alrs_pkg::CUT_W-1:0] need,
    output logic      [alrs_pkg::PIX_W-1:0]           low_cut,
    output logic      [alrs_pkg::PIX_W-1:0]           high_cut
);

    localparam int PROD_W = COUNT_WIDTH + alrs_pkg::CUT_W;
    localparam int ACC_W  = PROD_W + alrs_pkg::PIX_W;

    logic                       v1_reg, v2_reg;
    logic [alrs_pkg::PIX_W-1:0] i1_reg, i2_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [ACC_W-1:0]           acc_next;
    logic                       found_reg;
    logic [alrs_pkg::PIX_W-1:0] low_reg, high_reg;

    assign acc_next = acc_reg + ACC_W'(prod_reg);
    assign low_cut  = low_reg;
    assign high_cut = high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            v2_reg <= v1_reg;
            if (ctl.restart)
            begin
                found_reg <= 1'b0;
            end
            else if (v2_reg && !found_reg && (acc_next >= ACC_W'(need)))
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i1_reg   <= ctl.idx;
        i2_reg   <= i1_reg;
        prod_reg <= PROD_W'(hist_data) * PROD_W'(alrs_pkg::FRACTION_ONE);
        if (ctl.restart)
        begin
            acc_reg <= '0;
            if (ctl.high)
            begin
                high_reg <= '0;
            end
            else
            begin
                low_reg <= '0;
            end
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_next;
            if (!found_reg && (acc_next >= ACC_W'(need)))
            begin
                if (ctl.high)
                begin
                    high_reg <= i2_reg;
                end
                else
                begin
                    low_reg <= i2_reg;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/alrs_div.sv @@
// Restoring divider that splits full scale by the cut span, one quotient bit a cycle.
`default_nettype none

module alrs_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [alrs_pkg::PIX_W-1:0] divisor,
    output logic      [alrs_pkg::PIX_W-1:0] quot,
    output logic      [alrs_pkg::PIX_W-1:0] rem
);

    logic                       busy_reg;
    logic [2:0]                 step_reg;
    logic [alrs_pkg::PIX_W-1:0] quot_reg;
    logic [alrs_pkg::PIX_W-1:0] rem_reg;
    logic [alrs_pkg::PIX_W:0]   trial;
    logic                       ge;

    // The dividend is all ones, so every shifted-in bit is a one.
    assign trial = {rem_reg, 1'b1};
    assign ge    = trial >= {1'b0, divisor};
    assign quot  = quot_reg;
    assign rem   = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == 3'd7)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[alrs_pkg::PIX_W-2:0], ge};
            rem_reg  <= ge ? alrs_pkg::PIX_W'(trial - {1'b0, divisor})
                           : trial[alrs_pkg::PIX_W-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/alrs_lut.sv @@
// Stretch table of one channel: incremental build and a registered lookup port.
`default_nettype none

module alrs_lut (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire alrs_pkg::build_ctl_t       ctl,
    input  wire logic [alrs_pkg::PIX_W-1:0] low_cut,
    input  wire logic [alrs_pkg::PIX_W-1:0] high_cut,
    input  wire logic                       rd_en,
    input  wire logic [alrs_pkg::PIX_W-1:0] rd_addr,
    output logic      [alrs_pkg::PIX_W-1:0] rd_data
);

    localparam int W = alrs_pkg::PIX_W;

    logic [W-1:0] mem [2**W];
    logic [W-1:0] span;
    logic [W-1:0] step_q, step_r;
    logic [W:0]   qa_reg, qn;
    logic [W-1:0] ra_reg, rn;
    logic [W:0]   rsum;
    logic [W:0]   r2;
    logic         up;
    logic [W-1:0] entry;

    assign span = (high_cut > low_cut) ? (high_cut - low_cut) : W'(1);

    alrs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (ctl.div_start),
        .divisor (span),
        .quot    (step_q),
        .rem     (step_r)
    );

    // Each entry adds 255/span to the previous quotient and remainder.
    always_comb
    begin
        rsum = {1'b0, ra_reg} + {1'b0, step_r};
        qn   = qa_reg + {1'b0, step_q};
        if (rsum >= {1'b0, span})
        begin
            rsum = rsum - {1'b0, span};
            qn   = qn + (W+1)'(1);
        end
        rn = rsum[W-1:0];
        if (ctl.idx <= low_cut)
        begin
            qn = '0;
            rn = '0;
        end
        r2 = {rn, 1'b0};
        up = (r2 > {1'b0, span}) || ((r2 == {1'b0, span}) && qn[0]);
        if (ctl.idx <= low_cut)
        begin
            entry = '0;
        end
        else if (ctl.idx < high_cut)
        begin
            entry = qn[W-1:0] + W'(up);
        end
        else
        begin
            entry = alrs_pkg::FULL_SCALE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.idx] <= entry;
            qa_reg       <= qn;
            ra_reg       <= rn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
